### rtl/bia_pkg.sv
// Shared types and codes for the bitmap instance allocator.
// Request and result payloads, status codes and the controller/datapath handshake.
// No dependencies.
`default_nettype none

package bia_pkg;

  localparam int NUM_IN_W = 16;
  localparam int GRANT_W  = 14;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_IN_USE    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

  // Request operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic                operation;
    logic                specified;
    logic [NUM_IN_W-1:0] instance_number;
  } bia_req_t;

  typedef struct packed {
    logic [GRANT_W-1:0] granted_number;
    logic [2:0]         status;
  } bia_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;      // write a zero word at the sweep counter
    logic capture;     // latch the incoming request
    logic set_range;   // result: out of range
    logic split_q;     // word index of the requested number
    logic split_r;     // bit offset of the requested number
    logic look_rd;     // read the word that holds the requested number
    logic commit;      // decide a specified allocate or a free
    logic scan_start;  // restart the word scan at zero
    logic scan_step;   // issue the next scan read and look at the previous word
    logic grant;       // claim the lowest clear bit of the word that was found
    logic set_full;    // result: pool full
    logic push;        // move the result into the output register
  } bia_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;    // the sweep counter is at the last word
    logic in_dyn;      // incoming request is a dynamic allocate
    logic in_oor;      // incoming number is at or above capacity
    logic hit;         // the scanned word has a clear bit
    logic exhausted;   // the last word was scanned and is full
    logic out_free;    // the output register can take a result
  } bia_sts_t;

endpackage

`default_nettype wire

### rtl/bitmap_instance_allocator.sv
// Top level of the bitmap instance allocator: first-fit number pool.
// Instantiates bia_ctrl and bia_dpath; types from bia_pkg.
//
//   channel  ports                          carries
//   in       in_valid, in_ready, in_data    request: operation, specified, instance_number
//   out      out_valid, out_ready, out_data result: granted_number, status
//
// A dynamic allocate scans the bitmap one word per cycle from word 0 through the
// single memory read port. A specified allocate or a free splits the number into
// word index and bit offset, reads one word and writes it back if the check passes.
// After reset a clearing pass writes every word before in_ready rises.
// One request is in flight at a time; the next is taken while the result waits in
// the output register, and a stalled output holds only the final step.
`default_nettype none

module bitmap_instance_allocator #(
  parameter int CAPACITY  = 16384,
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bia_pkg::bia_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bia_pkg::bia_rsp_t  out_data
);
  import bia_pkg::*;

  bia_cmd_t cmd;
  bia_sts_t sts;

  bia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bia_dpath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/bia_ctrl.sv
// Request sequencer for the bitmap instance allocator.
// Issues bia_pkg command structs to bia_dpath and follows its status.
// Depends on bia_pkg.
`default_nettype none

module bia_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bia_pkg::bia_sts_t  sts,
  output bia_pkg::bia_cmd_t  cmd
);
  import bia_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_SPLIT_Q = 9'b000000100,
    S_SPLIT_R = 9'b000001000,
    S_LOOK    = 9'b000010000,
    S_CHECK   = 9'b000100000,
    S_SCAN    = 9'b001000000,
    S_FOUND   = 9'b010000000,
    S_DONE    = 9'b100000000
  } bia_state_t;

  bia_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          priority if (sts.in_dyn) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else if (sts.in_oor) begin
            cmd.set_range = 1'b1;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_SPLIT_Q;
          end
        end
      end
      S_SPLIT_Q: begin
        cmd.split_q = 1'b1;
        state_nxt   = S_SPLIT_R;
      end
      S_SPLIT_R: begin
        cmd.split_r = 1'b1;
        state_nxt   = S_LOOK;
      end
      S_LOOK: begin
        cmd.look_rd = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        priority if (sts.hit) begin
          state_nxt = S_FOUND;
        end else if (sts.exhausted) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_FOUND: begin
        cmd.grant = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free)
    else $error("result pushed while the output register is occupied");

  a_found_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOUND) |-> $past(sts.hit))
    else $error("claim without a word that has a clear bit");

  a_no_request_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) && !sts.clr_last |=> (state_r == S_CLEAR) && !in_ready)
    else $error("clearing pass left early");

endmodule

`default_nettype wire

### rtl/bia_dpath.sv
// Datapath of the bitmap instance allocator: bitmap memory, word scan,
// number split, result and output registers. Driven by bia_ctrl commands.
// Depends on bia_pkg.
`default_nettype none

module bia_dpath #(
  parameter int CAPACITY  = 16384,
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bia_pkg::bia_req_t  in_data,
  input  bia_pkg::bia_cmd_t  cmd,
  output bia_pkg::bia_sts_t  sts,
  output logic               out_valid,
  input  logic               out_ready,
  output bia_pkg::bia_rsp_t  out_data
);
  import bia_pkg::*;

  localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CNT_W     = $clog2(NUM_WORDS + 1);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int NUM_W     = $clog2(CAPACITY);
  localparam int LAST_BITS = CAPACITY - (NUM_WORDS - 1) * WORD_BITS;
  localparam int PROD_W    = NUM_W + 33;
  // Bits of the last word that lie beyond the capacity always read as used.
  localparam logic [WORD_BITS-1:0] PAD_MASK =
    ~((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_WORDS - 1);
  // Word index by reciprocal multiplication; exact for every 16-bit number.
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / WORD_BITS + 1);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [ADDR_W-1:0]    rd_idx_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 req_op_r;
  logic [NUM_W-1:0]     req_num_r;
  logic [ADDR_W-1:0]    word_r;
  logic [BIT_W-1:0]     bit_r;
  logic [2:0]           res_status_r;
  logic [NUM_W-1:0]     res_num_r;
  logic                 out_valid_r;
  bia_rsp_t             out_data_r;

  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd;
  logic                 scan_issue;
  logic [WORD_BITS-1:0] masked, low_clear, onehot, chk_word;
  logic [BIT_W-1:0]     low_pos;
  logic [NUM_W-1:0]     found_num, split_base;
  logic [PROD_W-1:0]    prod;
  logic                 bit_set, chk_ok;

  // Scan status
  assign masked    = rd_data_r | ((rd_idx_r == LAST_IDX) ? PAD_MASK : '0);
  assign low_clear = ~masked & (masked + WORD_BITS'(1));

  always_comb begin
    low_pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_clear[i]) begin
        low_pos = low_pos | BIT_W'(i);
      end
    end
  end

  assign found_num = NUM_W'(32'(rd_idx_r) * WORD_BITS) + NUM_W'(low_pos);

  assign sts.clr_last  = (cnt_r == CNT_W'(NUM_WORDS - 1));
  assign sts.in_dyn    = (in_data.operation == OP_ALLOC) && !in_data.specified;
  assign sts.in_oor    = (in_data.instance_number >= NUM_IN_W'(CAPACITY));
  assign sts.hit       = rd_vld_r && (masked != '1);
  assign sts.exhausted = rd_vld_r && (rd_idx_r == LAST_IDX) && (masked == '1);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign scan_issue = cmd.scan_step && (cnt_r < CNT_W'(NUM_WORDS)) && !sts.hit;

  // Specified allocate and free
  assign prod       = PROD_W'(req_num_r) * PROD_W'(RECIP);
  assign split_base = NUM_W'(32'(word_r) * WORD_BITS);
  assign bit_set    = rd_data_r[bit_r];
  assign onehot     = WORD_BITS'(1) << bit_r;
  assign chk_ok     = (req_op_r == OP_ALLOC) ? !bit_set : bit_set;
  assign chk_word   = (req_op_r == OP_ALLOC) ? (rd_data_r | onehot) : (rd_data_r & ~onehot);

  // Memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_r[ADDR_W-1:0];
    mem_wd = '0;
    priority if (cmd.clr_we) begin
      mem_we = 1'b1;
    end else if (cmd.commit && chk_ok) begin
      mem_we = 1'b1;
      mem_wa = word_r;
      mem_wd = chk_word;
    end else if (cmd.grant) begin
      mem_we = 1'b1;
      mem_wa = rd_idx_r;
      mem_wd = rd_data_r | low_clear;
    end
    mem_re = cmd.look_rd || scan_issue;
    mem_ra = cmd.look_rd ? word_r : cnt_r[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (cmd.clr_we || scan_issue) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.scan_start) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_vld_r <= scan_issue;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rd_idx_r <= cnt_r[ADDR_W-1:0];
    end
    if (cmd.capture) begin
      req_op_r  <= in_data.operation;
      req_num_r <= NUM_W'(in_data.instance_number);
    end
    if (cmd.split_q) begin
      word_r <= prod[32 +: ADDR_W];
    end
    if (cmd.split_r) begin
      bit_r <= BIT_W'(req_num_r - split_base);
    end
    priority if (cmd.set_range) begin
      res_status_r <= ST_RANGE;
      res_num_r    <= '0;
    end else if (cmd.set_full) begin
      res_status_r <= ST_FULL;
      res_num_r    <= '0;
    end else if (cmd.commit) begin
      if (chk_ok) begin
        res_status_r <= ST_OK;
        res_num_r    <= req_num_r;
      end else begin
        res_status_r <= (req_op_r == OP_ALLOC) ? ST_IN_USE : ST_NOT_ALLOC;
        res_num_r    <= '0;
      end
    end else if (cmd.grant) begin
      res_status_r <= ST_OK;
      res_num_r    <= found_num;
    end
    if (cmd.push) begin
      out_data_r.granted_number <= GRANT_W'(res_num_r);
      out_data_r.status         <= res_status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("bitmap read and write in the same cycle");

  a_fail_has_no_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != ST_OK) |-> (out_data_r.granted_number == '0))
    else $error("refused request carries a number");

  a_scan_index_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (32'(rd_idx_r) < NUM_WORDS))
    else $error("scan read beyond the last bitmap word");

endmodule

`default_nettype wire
